>>> hdl/mdb_pkg.sv
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types and constants of the multi-switch debouncer: switch phase
// codes, the layout of one state memory entry, register map and result word.
// ----------------------------------------------------------------------------
package mdb_pkg;

  // Switch inputs per frame and debounce counter width
  localparam int NUM_INPUTS = 16;
  localparam int COUNT_BITS = 8;
  localparam int IDX_W      = $clog2(NUM_INPUTS);

  // Fixed register field widths
  localparam int FRAME_CNT_W = 16;
  localparam int TICKS_W     = 8;

  // APB side
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Register reset values
  localparam logic [FRAME_CNT_W-1:0] WARMUP_RESET   = 16'd3000;
  localparam logic [FRAME_CNT_W-1:0] TICK_DIV_RESET = 16'd1000;

  // Register index (word address)
  typedef enum logic [2:0] {
    REG_WARMUP     = 3'd0,
    REG_TICK_DIV   = 3'd1,
    REG_CLOSE      = 3'd2,
    REG_OPEN       = 3'd3,
    REG_PUSHBUTTON = 3'd4,
    REG_PAIR       = 3'd5,
    REG_WAIT_MODE  = 3'd6
  } cfg_reg_e;

  // Pushbutton phase
  typedef enum logic [1:0] {
    PH_OPEN    = 2'd0,
    PH_CLOSED  = 2'd1,
    PH_OPENING = 2'd2,
    PH_CLOSING = 2'd3
  } phase_e;

  // One switch entry of the state memory
  typedef struct packed {
    phase_e                phase;
    logic [COUNT_BITS-1:0] count;
    logic                  contact;
  } sw_entry_t;

  localparam sw_entry_t ENTRY_RESET = '{phase: PH_CLOSED, count: '0, contact: 1'b0};

  // Configuration registers
  typedef struct packed {
    logic [FRAME_CNT_W-1:0] warmup_frames;
    logic [FRAME_CNT_W-1:0] tick_divide;
    logic [TICKS_W-1:0]     close_ticks;
    logic [TICKS_W-1:0]     open_ticks;
    logic [NUM_INPUTS-1:0]  pushbutton_mask;
    logic [NUM_INPUTS-1:0]  pair_mask;
    logic [NUM_INPUTS-1:0]  wait_mode_mask;
  } cfg_t;

  // Per-entry controls carried from the read step to the update step
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             last;
    logic             pb;
    logic             pair;
    logic             chg;
    logic             wbit;
    logic             split;
    logic             hold_mode;
    logic             tick;
  } step_t;

  // Result word
  typedef struct packed {
    logic [NUM_INPUTS-1:0] debounced_word;
    logic [NUM_INPUTS-1:0] changed_mask;
  } result_t;

endpackage

>>> hdl/mdb_frame_if.sv
// ----------------------------------------------------------------------------
// mdb_frame_if
// Input channel: one raw shift-register read word per serial frame.
// ----------------------------------------------------------------------------
interface mdb_frame_if import mdb_pkg::*;;

  logic                  valid;
  logic                  ready;
  logic [NUM_INPUTS-1:0] read_word;

  modport source (output valid, output read_word, input ready);
  modport sink   (input valid, input read_word, output ready);

endinterface

>>> hdl/mdb_result_if.sv
// ----------------------------------------------------------------------------
// mdb_result_if
// Output channel: debounced levels and the per-frame change mask.
// ----------------------------------------------------------------------------
interface mdb_result_if import mdb_pkg::*;;

  logic                  valid;
  logic                  ready;
  logic [NUM_INPUTS-1:0] debounced_word;
  logic [NUM_INPUTS-1:0] changed_mask;

  modport source (output valid, output debounced_word, output changed_mask, input ready);
  modport sink   (input valid, input debounced_word, input changed_mask, output ready);

endinterface

>>> hdl/mdb_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdb_cfg_regs
// APB register file: warm-up length, tick divider, debounce times and the
// per-switch role and mode masks.
// ----------------------------------------------------------------------------
module mdb_cfg_regs import mdb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warmup_frames   <= WARMUP_RESET;
      cfg_q.tick_divide     <= TICK_DIV_RESET;
      cfg_q.close_ticks     <= '0;
      cfg_q.open_ticks      <= '0;
      cfg_q.pushbutton_mask <= '0;
      cfg_q.pair_mask       <= '0;
      cfg_q.wait_mode_mask  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WARMUP:     cfg_q.warmup_frames   <= pwdata[FRAME_CNT_W-1:0];
        REG_TICK_DIV:   cfg_q.tick_divide     <= pwdata[FRAME_CNT_W-1:0];
        REG_CLOSE:      cfg_q.close_ticks     <= pwdata[TICKS_W-1:0];
        REG_OPEN:       cfg_q.open_ticks      <= pwdata[TICKS_W-1:0];
        REG_PUSHBUTTON: cfg_q.pushbutton_mask <= pwdata[NUM_INPUTS-1:0];
        REG_PAIR:       cfg_q.pair_mask       <= pwdata[NUM_INPUTS-1:0];
        REG_WAIT_MODE:  cfg_q.wait_mode_mask  <= pwdata[NUM_INPUTS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_WARMUP:     prdata = APB_DATA_W'(cfg_q.warmup_frames);
      REG_TICK_DIV:   prdata = APB_DATA_W'(cfg_q.tick_divide);
      REG_CLOSE:      prdata = APB_DATA_W'(cfg_q.close_ticks);
      REG_OPEN:       prdata = APB_DATA_W'(cfg_q.open_ticks);
      REG_PUSHBUTTON: prdata = APB_DATA_W'(cfg_q.pushbutton_mask);
      REG_PAIR:       prdata = APB_DATA_W'(cfg_q.pair_mask);
      REG_WAIT_MODE:  prdata = APB_DATA_W'(cfg_q.wait_mode_mask);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> hdl/mdb_state_mem.sv
// ----------------------------------------------------------------------------
// mdb_state_mem
// Per-switch state memory (phase, debounce count, contact level) with one
// synchronous read port and one write port. Entries not yet written since
// reset read as the closed, idle reset entry.
// ----------------------------------------------------------------------------
module mdb_state_mem import mdb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output sw_entry_t        rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  sw_entry_t        wr_data_i
);

  sw_entry_t             mem_q [NUM_INPUTS];
  sw_entry_t             rd_data_q;
  logic [NUM_INPUTS-1:0] vld_q;
  logic                  rd_vld_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : ENTRY_RESET;

endmodule

>>> hdl/mdb_entry_update.sv
// ----------------------------------------------------------------------------
// mdb_entry_update
// Next state of one switch: pair pattern tracking or the pushbutton
// open/closed/opening/closing machine, then the tick countdown and the end
// of debounce.
// ----------------------------------------------------------------------------
module mdb_entry_update import mdb_pkg::*; (
  input  sw_entry_t          entry_i,
  input  logic               deb_i,
  input  step_t              step_i,
  input  logic [TICKS_W-1:0] close_ticks_i,
  input  logic [TICKS_W-1:0] open_ticks_i,
  output sw_entry_t          entry_o,
  output logic               deb_o
);

  logic [COUNT_BITS-1:0] close_cnt;
  logic [COUNT_BITS-1:0] open_cnt;

  assign close_cnt = COUNT_BITS'(close_ticks_i);
  assign open_cnt  = COUNT_BITS'(open_ticks_i);

  always_comb begin
    entry_o = entry_i;
    deb_o   = deb_i;

    // Apply the contact change
    if (step_i.pair) begin
      if (step_i.chg) begin
        entry_o.contact = step_i.wbit;
        // Follow 01 and 10, hold on 00 and 11
        if (step_i.split) begin
          deb_o = step_i.wbit;
        end
      end
    end else if (step_i.pb && step_i.chg) begin
      entry_o.contact = step_i.wbit;
      case (entry_i.phase)
        PH_OPEN: begin
          if (!step_i.wbit) begin
            if (close_cnt == '0) begin
              deb_o         = 1'b0;
              entry_o.phase = PH_CLOSED;
            end else begin
              if (!step_i.hold_mode) deb_o = 1'b0;
              entry_o.phase = PH_CLOSING;
              entry_o.count = close_cnt;
            end
          end else begin
            deb_o = 1'b1;
          end
        end
        PH_CLOSED: begin
          if (step_i.wbit) begin
            if (open_cnt == '0) begin
              deb_o         = 1'b1;
              entry_o.phase = PH_OPEN;
            end else begin
              if (!step_i.hold_mode) deb_o = 1'b1;
              entry_o.phase = PH_OPENING;
              entry_o.count = open_cnt;
            end
          end else begin
            deb_o = 1'b0;
          end
        end
        PH_OPENING: entry_o.count = open_cnt;
        PH_CLOSING: entry_o.count = close_cnt;
        default: ;
      endcase
    end

    // Count down on a tick and settle at zero
    if (step_i.tick && (entry_o.count != '0)) begin
      entry_o.count = entry_o.count - 1'b1;
      if (entry_o.count == '0) begin
        case (entry_o.phase)
          PH_OPENING: begin
            if (!entry_o.contact) begin
              entry_o.phase = PH_CLOSED;
              if (!step_i.hold_mode) deb_o = 1'b0;
            end else begin
              entry_o.phase = PH_OPEN;
              if (step_i.hold_mode) deb_o = 1'b1;
            end
          end
          PH_CLOSING: begin
            if (entry_o.contact) begin
              entry_o.phase = PH_OPEN;
              if (!step_i.hold_mode) deb_o = 1'b1;
            end else begin
              entry_o.phase = PH_CLOSED;
              if (step_i.hold_mode) deb_o = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hdl/mdb_result_fifo.sv
// ----------------------------------------------------------------------------
// mdb_result_fifo
// Two-word result queue between the switch sweep and the output channel.
// ----------------------------------------------------------------------------
module mdb_result_fifo import mdb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  // Store pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

endmodule

>>> hdl/multi_switch_debouncer_core.sv
// ----------------------------------------------------------------------------
// multi_switch_debouncer_core
// Flow: a processed frame is swept over the per-switch state memory, one
// read/modify/write per switch, before its result word is queued; a warm-up
// frame queues its word at once. The next frame can be accepted while the
// sweep reads its last entry, if a result queue slot is free.
// Reset: asynchronous, active low; state reads as closed/idle, no clear pass.
// ----------------------------------------------------------------------------
module multi_switch_debouncer_core import mdb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mdb_frame_if.sink             frame_i,
  mdb_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  // Frame context
  logic [NUM_INPUTS-1:0]  prev_q;
  logic [NUM_INPUTS-1:0]  word_q;
  logic [NUM_INPUTS-1:0]  diff_q;
  logic                   tick_q;
  logic [FRAME_CNT_W-1:0] warm_q;
  logic [FRAME_CNT_W-1:0] presc_q;
  logic [FRAME_CNT_W:0]   presc_sum;
  logic                   tick_now;

  // Sweep
  logic             rd_busy_q, rd_busy_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_last;
  logic             s1_valid_q;
  step_t            s1_q, s1_d;

  // Per-switch role vectors
  logic [NUM_INPUTS-1:0] pair_v;
  logic [NUM_INPUTS-1:0] pdiff_v;
  logic [NUM_INPUTS-1:0] split_v;

  // Memory and update
  sw_entry_t mem_rd;
  sw_entry_t entry_new;
  logic      deb_old;
  logic      deb_new;

  // Levels and results
  logic [NUM_INPUTS-1:0] deb_q, deb_d;
  logic [NUM_INPUTS-1:0] chg_q, chg_d;
  logic [1:0]            cred_q, cred_d;
  logic                  warm_phase;
  logic                  idle;
  logic                  accept;
  logic                  pop;
  logic                  push;
  result_t               push_data;
  result_t               head;

  mdb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input handshake
  assign warm_phase    = (warm_q < cfg.warmup_frames);
  assign idle          = !rd_busy_q && !s1_valid_q;
  assign rd_last       = (rd_idx_q == IDX_W'(NUM_INPUTS - 1));
  assign frame_i.ready = (cred_q != '0) && (warm_phase ? idle : (!rd_busy_q || rd_last));
  assign accept        = frame_i.valid && frame_i.ready;
  assign pop           = result_o.valid && result_o.ready;

  // Prescaler: a tick when the frame count reaches the divider
  assign presc_sum = {1'b0, presc_q} + 1'b1;
  assign tick_now  = (presc_sum >= {1'b0, cfg.tick_divide});

  // Latch frame context at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      warm_q  <= '0;
      presc_q <= '0;
    end else if (accept) begin
      if (warm_phase) begin
        warm_q <= warm_q + 1'b1;
      end else begin
        prev_q  <= frame_i.read_word;
        presc_q <= tick_now ? '0 : presc_sum[FRAME_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !warm_phase) begin
      word_q <= frame_i.read_word;
      diff_q <= prev_q ^ frame_i.read_word;
      tick_q <= tick_now;
    end
  end

  // Role, pair change and pair split per switch
  always_comb begin
    pair_v  = '0;
    pdiff_v = diff_q;
    split_v = '0;
    for (int j = 0; j < NUM_INPUTS; j++) begin
      if ((j % 2) == 0) begin
        if (j + 1 < NUM_INPUTS) begin
          pair_v[j]  = cfg.pair_mask[j];
          pdiff_v[j] = diff_q[j] | diff_q[j+1];
          split_v[j] = word_q[j] ^ word_q[j+1];
        end
      end else begin
        pair_v[j]  = cfg.pair_mask[j-1];
        pdiff_v[j] = diff_q[j-1] | diff_q[j];
        split_v[j] = word_q[j-1] ^ word_q[j];
      end
    end
  end

  // Read step: advance the sweep index
  always_comb begin
    rd_busy_d = rd_busy_q;
    rd_idx_d  = rd_idx_q;
    if (accept && !warm_phase) begin
      rd_busy_d = 1'b1;
      rd_idx_d  = '0;
    end else if (rd_busy_q && rd_last) begin
      rd_busy_d = 1'b0;
    end else if (rd_busy_q) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  // Gather controls for the entry being read
  always_comb begin
    s1_d.idx       = rd_idx_q;
    s1_d.first     = (rd_idx_q == '0);
    s1_d.last      = rd_last;
    s1_d.pair      = pair_v[rd_idx_q];
    s1_d.pb        = cfg.pushbutton_mask[rd_idx_q] && !pair_v[rd_idx_q];
    s1_d.chg       = pair_v[rd_idx_q] ? pdiff_v[rd_idx_q] : diff_q[rd_idx_q];
    s1_d.wbit      = word_q[rd_idx_q];
    s1_d.split     = split_v[rd_idx_q];
    s1_d.hold_mode = cfg.wait_mode_mask[rd_idx_q];
    s1_d.tick      = tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q  <= 1'b0;
      rd_idx_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      rd_busy_q  <= rd_busy_d;
      rd_idx_q   <= rd_idx_d;
      s1_valid_q <= rd_busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_busy_q) begin
      s1_q <= s1_d;
    end
  end

  mdb_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_busy_q),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (mem_rd),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_q.idx),
    .wr_data_i (entry_new)
  );

  assign deb_old = deb_q[s1_q.idx];

  mdb_entry_update u_upd (
    .entry_i       (mem_rd),
    .deb_i         (deb_old),
    .step_i        (s1_q),
    .close_ticks_i (cfg.close_ticks),
    .open_ticks_i  (cfg.open_ticks),
    .entry_o       (entry_new),
    .deb_o         (deb_new)
  );

  // Update step: commit debounced level and collect the change mask
  always_comb begin
    deb_d = deb_q;
    chg_d = chg_q;
    if (s1_valid_q) begin
      deb_d[s1_q.idx] = deb_new;
      if (s1_q.first) begin
        chg_d = '0;
      end
      chg_d[s1_q.idx] = deb_new ^ deb_old;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= '0;
      chg_q <= '0;
    end else begin
      deb_q <= deb_d;
      chg_q <= chg_d;
    end
  end

  // Result words: warm-up frames report the held levels at once
  assign push = (accept && warm_phase) || (s1_valid_q && s1_q.last);

  always_comb begin
    if (s1_valid_q) begin
      push_data.debounced_word = deb_d;
      push_data.changed_mask   = chg_d;
    end else begin
      push_data.debounced_word = deb_q;
      push_data.changed_mask   = '0;
    end
  end

  // Reserve a queue slot per accepted frame, release on pop
  assign cred_d = cred_q + {1'b0, pop} - {1'b0, accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= 2'd2;
    end else begin
      cred_q <= cred_d;
    end
  end

  mdb_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (result_o.valid),
    .data_o      (head)
  );

  assign result_o.debounced_word = head.debounced_word;
  assign result_o.changed_mask   = head.changed_mask;

`ifndef SYNTH
  // Read and write of the sweep never hit the same entry
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_busy_q && s1_valid_q) |-> (rd_idx_q != s1_q.idx))
    else $error("state memory read and write collide");

  // All credits home means nothing queued or in flight
  a_cred_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cred_q == 2'd2) |-> (!result_o.valid && idle))
    else $error("credits out of step with queued words");

  // A warm-up frame yields a word on the next cycle
  a_warm_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && warm_phase) |=> result_o.valid)
    else $error("warm-up frame without result");

  // The sweep walks the entries in order without gaps
  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_busy_q && !rd_last) |=> (rd_busy_q && (rd_idx_q == $past(rd_idx_q) + 1'b1)))
    else $error("sweep index skipped");
`endif

endmodule
